### hdl/triangle_primitive_assembler_unit_macros.svh
// Assertion macros shared by the triangle primitive assembler RTL.
`ifndef TRIANGLE_PRIMITIVE_ASSEMBLER_UNIT_MACROS_SVH
`define TRIANGLE_PRIMITIVE_ASSEMBLER_UNIT_MACROS_SVH

// Checked property, disabled while reset is asserted.
`define TPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked property that also holds during reset.
`define TPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/tpa_pkg.sv
// Shared types and constants of the triangle primitive assembler.
package tpa_pkg;

  localparam int unsigned VERTEX_ID_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  typedef enum logic [1:0] {
    MODE_LIST  = 2'd0,
    MODE_STRIP = 2'd1,
    MODE_FAN   = 2'd2
  } draw_mode_e;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ACT_ANCHOR     = 3'd0,
    ACT_SECOND     = 3'd1,
    ACT_LIST       = 3'd2,
    ACT_STRIP_EVEN = 3'd3,
    ACT_STRIP_ODD  = 3'd4,
    ACT_FAN        = 3'd5
  } action_e;

  typedef struct packed {
    action_e action;
    logic    last;
  } tpa_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tpa_qstat_t;

endpackage

### hdl/triangle_primitive_assembler_unit.sv
// Top level of the triangle primitive assembler: front end, request queue and back end.
//
//   Channel   Handshake                Payload
//   --------  -----------------------  ----------------------------------------------
//   vertex    push / full              vertex_id_i, end_of_draw_i
//   result    empty / pop              tri_valid_o, corner_a_o, corner_b_o,
//                                      corner_c_o, draw_done_o
//   config    cfg_valid_i/cfg_ready_o  cfg_data_i (draw mode)
//
// One vertex is taken per cycle while the queue is not full; its result is written to a queue
// entry and then to the result register, limited by the single result register.
// Reset clears the draw mode to list, the phase and winding tracking, and all queue state.
// A stalled result holds the back end, and the two-entry queue then fills and raises full.
// Configuration writes are always ready and take effect on the next classified vertex.
module triangle_primitive_assembler_unit #(
  parameter int unsigned VertexIdBits = tpa_pkg::VERTEX_ID_BITS_DEF,
  parameter int unsigned QueueDepth   = tpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_data_i,
  input  logic                    push,
  output logic                    full,
  input  logic [VertexIdBits-1:0] vertex_id_i,
  input  logic                    end_of_draw_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    tri_valid_o,
  output logic [VertexIdBits-1:0] corner_a_o,
  output logic [VertexIdBits-1:0] corner_b_o,
  output logic [VertexIdBits-1:0] corner_c_o,
  output logic                    draw_done_o
);
  import tpa_pkg::*;

  `include "triangle_primitive_assembler_unit_macros.svh"

  localparam int unsigned QBits = $bits(tpa_ctl_t) + VertexIdBits;

  tpa_qstat_t              q_stat;
  tpa_ctl_t                f_ctl, b_ctl;
  logic [VertexIdBits-1:0] f_vid, b_vid;
  logic                    q_push, q_pop;
  logic [QBits-1:0]        q_rd_data;

  assign cfg_ready_o = 1'b1;
  assign full        = q_stat.full;

  tpa_front #(
    .VertexIdBits(VertexIdBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .vertex_id_i  (vertex_id_i),
    .end_of_draw_i(end_of_draw_i),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_ctl_o      (f_ctl),
    .q_vid_o      (f_vid)
  );

  tpa_queue #(
    .DataBits(QBits),
    .Depth   (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_push),
    .wr_data_i({f_ctl, f_vid}),
    .rd_en_i  (q_pop),
    .rd_data_o(q_rd_data),
    .stat_o   (q_stat)
  );

  assign b_ctl = q_rd_data[QBits-1:VertexIdBits];
  assign b_vid = q_rd_data[VertexIdBits-1:0];

  tpa_back #(
    .VertexIdBits(VertexIdBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_ctl_i    (b_ctl),
    .q_vid_i    (b_vid),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .tri_valid_o(tri_valid_o),
    .corner_a_o (corner_a_o),
    .corner_b_o (corner_b_o),
    .corner_c_o (corner_c_o),
    .draw_done_o(draw_done_o)
  );

  `TPA_ASSERT(a_result_held, (!empty && !pop) |=> !empty, "waiting result was dropped")
  `TPA_ASSERT(a_drain_clears, (q_stat.empty && !empty && pop) |=> empty, "result register did not drain")
  `TPA_ASSERT(a_fast_path, (q_push && q_stat.empty && (empty || pop)) |=> q_pop, "queued request was not forwarded")
  `TPA_ASSERT(a_queue_flags, !(q_stat.full && q_stat.empty), "queue full and empty at once")

endmodule

### hdl/tpa_front.sv
// Front end: accepts vertices, tracks draw phase and winding, and classifies each vertex.
module tpa_front #(
  parameter int unsigned VertexIdBits = tpa_pkg::VERTEX_ID_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [1:0]              cfg_data_i,
  input  logic                    push_i,
  input  logic [VertexIdBits-1:0] vertex_id_i,
  input  logic                    end_of_draw_i,
  input  tpa_pkg::tpa_qstat_t     q_stat_i,
  output logic                    q_push_o,
  output tpa_pkg::tpa_ctl_t       q_ctl_o,
  output logic [VertexIdBits-1:0] q_vid_o
);
  import tpa_pkg::*;

  logic [1:0] mode_q;
  phase_e     phase_q, phase_d;
  logic       odd_q, odd_d;
  action_e    action;

  assign q_push_o = push_i && !q_stat_i.full;

  always_comb begin
    phase_d = phase_q;
    odd_d   = odd_q;
    action  = ACT_ANCHOR;
    case (phase_q)
      PH_NONE: begin
        action  = ACT_ANCHOR;
        phase_d = PH_ONE;
      end
      PH_ONE: begin
        action  = ACT_SECOND;
        phase_d = PH_TWO;
      end
      PH_TWO: begin
        case (mode_q)
          MODE_STRIP: begin
            action = odd_q ? ACT_STRIP_ODD : ACT_STRIP_EVEN;
            odd_d  = !odd_q;
          end
          MODE_FAN: begin
            action = ACT_FAN;
          end
          default: begin
            // The unused mode code assembles like a list.
            action  = ACT_LIST;
            phase_d = PH_NONE;
          end
        endcase
      end
      default: begin
        action  = ACT_ANCHOR;
        phase_d = PH_ONE;
      end
    endcase
    if (end_of_draw_i) begin
      phase_d = PH_NONE;
      odd_d   = 1'b0;
    end
  end

  assign q_ctl_o.action = action;
  assign q_ctl_o.last   = end_of_draw_i;
  assign q_vid_o        = vertex_id_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LIST;
      phase_q <= PH_NONE;
      odd_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (q_push_o) begin
        phase_q <= phase_d;
        odd_q   <= odd_d;
      end
    end
  end

endmodule

### hdl/tpa_queue.sv
// Short request queue between the classifying front end and the assembling back end.
module tpa_queue #(
  parameter int unsigned DataBits = 8,
  parameter int unsigned Depth    = tpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [DataBits-1:0] wr_data_i,
  input  logic                rd_en_i,
  output logic [DataBits-1:0] rd_data_o,
  output tpa_pkg::tpa_qstat_t stat_o
);
  import tpa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataBits-1:0] mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (rd_en_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!wr_en_i && rd_en_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### hdl/tpa_back.sv
// Back end: holds the retained vertices, forms triangles and drives the result register.
module tpa_back #(
  parameter int unsigned VertexIdBits = tpa_pkg::VERTEX_ID_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tpa_pkg::tpa_qstat_t     q_stat_i,
  input  tpa_pkg::tpa_ctl_t       q_ctl_i,
  input  logic [VertexIdBits-1:0] q_vid_i,
  output logic                    q_pop_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output logic                    tri_valid_o,
  output logic [VertexIdBits-1:0] corner_a_o,
  output logic [VertexIdBits-1:0] corner_b_o,
  output logic [VertexIdBits-1:0] corner_c_o,
  output logic                    draw_done_o
);
  import tpa_pkg::*;

  logic [VertexIdBits-1:0] anchor_q, anchor_d;
  logic [VertexIdBits-1:0] older_q, older_d;
  logic [VertexIdBits-1:0] newer_q, newer_d;
  logic                    out_valid_q;
  logic                    tri_q, tri_d;
  logic [VertexIdBits-1:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic                    done_q;

  // A request moves on whenever the result register is free or is being drained.
  assign q_pop_o = !q_stat_i.empty && (!out_valid_q || pop_i);

  always_comb begin
    anchor_d = anchor_q;
    older_d  = older_q;
    newer_d  = newer_q;
    tri_d    = 1'b0;
    a_d      = '0;
    b_d      = '0;
    c_d      = '0;
    case (q_ctl_i.action)
      ACT_ANCHOR: begin
        anchor_d = q_vid_i;
        older_d  = q_vid_i;
      end
      ACT_SECOND: begin
        newer_d = q_vid_i;
      end
      ACT_LIST: begin
        tri_d = 1'b1;
        a_d   = older_q;
        b_d   = newer_q;
        c_d   = q_vid_i;
      end
      ACT_STRIP_EVEN: begin
        tri_d   = 1'b1;
        a_d     = older_q;
        b_d     = newer_q;
        c_d     = q_vid_i;
        older_d = newer_q;
        newer_d = q_vid_i;
      end
      ACT_STRIP_ODD: begin
        tri_d   = 1'b1;
        a_d     = newer_q;
        b_d     = older_q;
        c_d     = q_vid_i;
        older_d = newer_q;
        newer_d = q_vid_i;
      end
      ACT_FAN: begin
        tri_d   = 1'b1;
        a_d     = anchor_q;
        b_d     = newer_q;
        c_d     = q_vid_i;
        newer_d = q_vid_i;
      end
      default: begin
        tri_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      anchor_q <= anchor_d;
      older_q  <= older_d;
      newer_q  <= newer_d;
      tri_q    <= tri_d;
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
      done_q   <= q_ctl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o     = !out_valid_q;
  assign tri_valid_o = tri_q;
  assign corner_a_o  = a_q;
  assign corner_b_o  = b_q;
  assign corner_c_o  = c_q;
  assign draw_done_o = done_q;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the triangle primitive assembler: vertex queue in, triangles out.
`timescale 1ns / 100ps

module tb_top;
  import tpa_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned ID_BITS = VERTEX_ID_BITS_DEF;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [ID_BITS-1:0] vertex_id;
    logic               end_of_draw;
  } vertex_req_t;

  typedef struct packed {
    logic               tri_valid;
    logic [ID_BITS-1:0] corner_a;
    logic [ID_BITS-1:0] corner_b;
    logic [ID_BITS-1:0] corner_c;
    logic               draw_done;
  } tri_result_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic [ID_BITS-1:0] vertex_id_i = '0;
  logic               end_of_draw_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic               tri_valid_o;
  logic [ID_BITS-1:0] corner_a_o;
  logic [ID_BITS-1:0] corner_b_o;
  logic [ID_BITS-1:0] corner_c_o;
  logic               draw_done_o;

  // Stimulus and scoreboard state.
  vertex_req_t vertices_to_send[$];
  tri_result_t predicted_triangles[$];
  bit          vertex_taken = 1'b0;
  int unsigned vertices_accepted = 0;
  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          receiver_held = 1'b0;

  // Predictor copy of the block's draw mode and assembly state.
  logic [1:0]         asm_mode = MODE_LIST;
  logic [ID_BITS-1:0] draw_first = '0;
  logic [ID_BITS-1:0] prev_older = '0;
  logic [ID_BITS-1:0] prev_newer = '0;
  phase_e             held_count = PH_NONE;
  logic               odd_winding = 1'b0;

  triangle_primitive_assembler_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .vertex_id_i   (vertex_id_i),
    .end_of_draw_i (end_of_draw_i),
    .empty         (empty),
    .pop           (pop),
    .tri_valid_o   (tri_valid_o),
    .corner_a_o    (corner_a_o),
    .corner_b_o    (corner_b_o),
    .corner_c_o    (corner_c_o),
    .draw_done_o   (draw_done_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic tri_result_t assemble_vertex(input vertex_req_t req);
    tri_result_t res;
    res = '0;
    res.draw_done = req.end_of_draw;
    case (held_count)
      PH_NONE: begin
        draw_first = req.vertex_id;
        prev_older = req.vertex_id;
        held_count = PH_ONE;
      end
      PH_ONE: begin
        prev_newer = req.vertex_id;
        held_count = PH_TWO;
      end
      default: begin
        res.tri_valid = 1'b1;
        res.corner_c = req.vertex_id;
        if (asm_mode == MODE_STRIP) begin
          // Odd strip triangles swap the first two corners to keep the winding.
          res.corner_a = odd_winding ? prev_newer : prev_older;
          res.corner_b = odd_winding ? prev_older : prev_newer;
          prev_older = prev_newer;
          prev_newer = req.vertex_id;
          odd_winding = ~odd_winding;
        end else if (asm_mode == MODE_FAN) begin
          res.corner_a = draw_first;
          res.corner_b = prev_newer;
          prev_newer = req.vertex_id;
        end else begin
          res.corner_a = prev_older;
          res.corner_b = prev_newer;
          held_count = PH_NONE;
        end
      end
    endcase
    if (req.end_of_draw) begin
      draw_first = '0;
      prev_older = '0;
      prev_newer = '0;
      held_count = PH_NONE;
      odd_winding = 1'b0;
    end
    return res;
  endfunction

  function automatic void note_failure(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("[%0t] ERROR: %s", $realtime, what);
  endfunction

  // Monitor: records accepted vertices and checks every popped result.
  always @(posedge clk_i) begin
    tri_result_t got;
    tri_result_t want;
    vertex_taken = rst_ni && push && !full;
    if (vertex_taken) begin
      predicted_triangles.insert(predicted_triangles.size(),
                                 assemble_vertex('{vertex_id_i, end_of_draw_i}));
      vertices_accepted++;
    end
    if (rst_ni && pop && !empty) begin
      got = '{tri_valid_o, corner_a_o, corner_b_o, corner_c_o, draw_done_o};
      if (predicted_triangles.size() == 0) begin
        note_failure($sformatf("result with no request pending: valid=%0b a=%h b=%h c=%h done=%0b",
                               got.tri_valid, got.corner_a, got.corner_b, got.corner_c,
                               got.draw_done));
      end else begin
        want = predicted_triangles.pop_front();
        if (got.tri_valid !== want.tri_valid || got.corner_a !== want.corner_a ||
            got.corner_b !== want.corner_b || got.corner_c !== want.corner_c ||
            got.draw_done !== want.draw_done)
          note_failure($sformatf({"mismatch: expected valid=%0b a=%h b=%h c=%h done=%0b, ",
                                  "got valid=%0b a=%h b=%h c=%h done=%0b"},
                                 want.tri_valid, want.corner_a, want.corner_b, want.corner_c,
                                 want.draw_done, got.tri_valid, got.corner_a, got.corner_b,
                                 got.corner_c, got.draw_done));
      end
    end
  end

  // Vertex driver: offers the front of the pending list, with random gaps between requests.
  always @(negedge clk_i) begin
    if (vertex_taken)
      void'(vertices_to_send.pop_front());
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || vertex_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (vertices_to_send.size() == 0) begin
        push <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        tx_gap = $urandom_range(0, 9);
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        vertex_id_i <= vertices_to_send[0].vertex_id;
        end_of_draw_i <= vertices_to_send[0].end_of_draw;
      end
    end
  end

  // Result receiver: pops with random stall bursts, or not at all during the long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni || receiver_held) begin
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      rx_gap = $urandom_range(0, 9);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the block fills and raises full.
  initial begin : result_hold_off
    while (vertices_accepted < 300 || vertices_to_send.size() < 40)
      @(negedge clk_i);
    receiver_held = 1'b1;
    repeat (120) @(negedge clk_i);
    receiver_held = 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic add_vertex(input logic [ID_BITS-1:0] id, input logic last);
    vertices_to_send.insert(vertices_to_send.size(), '{id, last});
  endtask

  task automatic wait_until_drained();
    while (vertices_to_send.size() != 0 || predicted_triangles.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_draw_mode(input logic [1:0] mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    asm_mode = mode;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ID_BITS-1:0] random_vertex();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
    endcase
  endfunction

  // Mostly short well-formed draws, a few long ones; a draw cut off at the end stays open.
  task automatic add_random_phase(input int unsigned count);
    int unsigned added;
    int unsigned draw_len;
    added = 0;
    while (added < count) begin
      draw_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < draw_len && added < count; i++) begin
        add_vertex(random_vertex(), i == draw_len - 1);
        added++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 10;

    // List mode from reset: one full triangle, then a draw that ends with leftovers.
    add_vertex('0, 1'b0);
    add_vertex('1, 1'b0);
    add_vertex(16'h8000, 1'b0);
    add_vertex(16'h0001, 1'b0);
    add_vertex(16'h0002, 1'b1);
    add_vertex(16'h0007, 1'b1);
    wait_until_drained();

    // Strip with an odd vertex count must keep its last triangle.
    set_draw_mode(MODE_STRIP);
    for (int i = 0; i < 5; i++)
      add_vertex(ID_BITS'(16'h0010 + i), i == 4);
    wait_until_drained();

    // Fan keeps its last triangle too; the second draw stays open across a mode change.
    set_draw_mode(MODE_FAN);
    for (int i = 0; i < 4; i++)
      add_vertex(ID_BITS'(16'h0020 + i), i == 3);
    for (int i = 0; i < 3; i++)
      add_vertex(ID_BITS'(16'h0030 + i), 1'b0);
    wait_until_drained();
    set_draw_mode(MODE_STRIP);
    add_vertex(16'h0033, 1'b0);
    add_vertex(16'h0034, 1'b1);
    wait_until_drained();

    // The unused mode code assembles like a list.
    set_draw_mode(MODE_UNUSED);
    for (int i = 0; i < 3; i++)
      add_vertex(ID_BITS'(16'h0040 + i), i == 2);
    add_vertex('1, 1'b0);
    add_vertex('0, 1'b1);

    for (int unsigned p = 0; p < 8; p++) begin
      wait_until_drained();
      set_draw_mode(p < 4 ? p[1:0] : 2'($urandom_range(0, 3)));
      idle_pct = (p == 7) ? 0 : $urandom_range(5, 30);
      add_random_phase(119);
    end

    wait_until_drained();
    repeat (10) @(negedge clk_i);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
